// ===== design/spin_adapted_triple_index_map_unit_macros.svh =====
// assertion macros for the spin-adapted triple index map unit
`ifndef SPIN_ADAPTED_TRIPLE_INDEX_MAP_UNIT_MACROS_SVH
`define SPIN_ADAPTED_TRIPLE_INDEX_MAP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define SATIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define SATIM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SATIM_ASSERT(lbl, prop, msg)
`define SATIM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== design/satim_pkg.sv =====
// shared types, constants and binomial tables of the triple index map
package satim_pkg;

  localparam int OrbWidth     = 4;
  localparam int NumWidth     = 5;
  localparam int TblDepth     = 1 << NumWidth;
  localparam int IndexWidth   = 11;
  localparam int CalcWidth    = 16;
  localparam int CoefWidth    = 18;
  localparam int CountWidth   = 2;

  localparam logic [NumWidth-1:0] SpatialOrbitalsReset = 5'd16;

  localparam logic [CountWidth-1:0] TermsNone = 2'd0;
  localparam logic [CountWidth-1:0] TermsOne  = 2'd1;
  localparam logic [CountWidth-1:0] TermsTwo  = 2'd2;

  // signed q2.16 coefficient magnitudes
  localparam logic signed [CoefWidth-1:0] CoefOne       = 18'sd65536;
  localparam logic signed [CoefWidth-1:0] CoefHalf      = 18'sd32768;
  localparam logic signed [CoefWidth-1:0] CoefHalfSqrt3 = 18'sd56756;
  localparam logic signed [CoefWidth-1:0] CoefHalfSqrt2 = 18'sd46341;
  localparam logic signed [CoefWidth-1:0] CoefHalfSqrt6 = 18'sd80265;

  typedef logic [CalcWidth-1:0] comb_tbl_t [TblDepth];

  // decoded item: which index form to build and its coefficients
  typedef struct packed {
    logic [CountWidth-1:0]       cnt;
    logic                        pair;
    logic                        quart;
    logic                        spin1;
    logic [NumWidth-1:0]         n;
    logic [OrbWidth-1:0]         x;
    logic [OrbWidth-1:0]         y;
    logic [OrbWidth-1:0]         z;
    logic signed [CoefWidth-1:0] coef0;
    logic signed [CoefWidth-1:0] coef1;
  } dec_t;

  function automatic comb_tbl_t build_choose2();
    comb_tbl_t t;
    for (int i = 0; i < TblDepth; i++) begin
      t[i] = CalcWidth'((i * (i - 1)) / 2);
    end
    return t;
  endfunction

  function automatic comb_tbl_t build_choose3();
    comb_tbl_t t;
    for (int i = 0; i < TblDepth; i++) begin
      t[i] = CalcWidth'((i * (i - 1) * (i - 2)) / 6);
    end
    return t;
  endfunction

  localparam comb_tbl_t Choose2Table = build_choose2();
  localparam comb_tbl_t Choose3Table = build_choose3();

endpackage

// ===== design/satim_decode.sv =====
// first stage logic: range check, case split, sorting and coefficient choice
module satim_decode import satim_pkg::*; #(
  parameter int MAX_ORBITALS = 16
) (
  input  logic [NumWidth-1:0] spatial_orbitals_i,
  input  logic                spin_block_i,
  input  logic                pair_spin_i,
  input  logic [OrbWidth-1:0] orbital_first_i,
  input  logic [OrbWidth-1:0] orbital_second_i,
  input  logic [OrbWidth-1:0] orbital_third_i,
  output dec_t                dec_o
);

  localparam logic [NumWidth:0] MaxOrb = (NumWidth + 1)'(MAX_ORBITALS);

  logic [NumWidth-1:0]         n_eff;
  logic [OrbWidth-1:0]         a, b, c, lo, hi;
  logic                        s, in_range, neg;
  logic signed [CoefWidth-1:0] m0, m1;

  assign a = orbital_first_i;
  assign b = orbital_second_i;
  assign c = orbital_third_i;
  assign s = pair_spin_i;

  // register values above the build limit are clamped
  assign n_eff = ({1'b0, spatial_orbitals_i} > MaxOrb) ? MaxOrb[NumWidth-1:0]
                                                      : spatial_orbitals_i;
  assign in_range = (NumWidth'(a) < n_eff) && (NumWidth'(b) < n_eff) &&
                    (NumWidth'(c) < n_eff);
  assign lo = (a < b) ? a : b;
  assign hi = (a < b) ? b : a;

  always_comb begin
    dec_o   = '0;
    dec_o.n = n_eff;
    m0      = '0;
    m1      = '0;
    neg     = 1'b0;
    if (in_range && !(a == b && b == c)) begin
      if (!spin_block_i) begin
        if (a == b) begin
          if (!s) begin
            dec_o.cnt  = TermsOne;
            dec_o.pair = 1'b1;
            dec_o.x    = a;
            dec_o.z    = c;
            m0         = CoefOne;
          end
        end else if (a < b && b < c) begin
          dec_o.cnt   = TermsOne;
          dec_o.spin1 = s;
          {dec_o.x, dec_o.y, dec_o.z} = {a, b, c};
          m0          = CoefOne;
        end else begin
          // swapped pair flips sign for pair spin one
          neg = (a > b) && s;
          if (a > b && c > hi) begin
            dec_o.cnt   = TermsOne;
            dec_o.spin1 = s;
            {dec_o.x, dec_o.y, dec_o.z} = {b, a, c};
            m0          = CoefOne;
          end else if (c < lo) begin
            dec_o.cnt = TermsTwo;
            {dec_o.x, dec_o.y, dec_o.z} = {c, lo, hi};
            m0 = s ? -CoefHalfSqrt3 : -CoefHalf;
            m1 = s ? -CoefHalf : CoefHalfSqrt3;
          end else if (c == lo) begin
            dec_o.cnt  = TermsOne;
            dec_o.pair = 1'b1;
            dec_o.x    = c;
            dec_o.z    = hi;
            m0 = s ? -CoefHalfSqrt6 : -CoefHalfSqrt2;
          end else if (c < hi) begin
            dec_o.cnt = TermsTwo;
            {dec_o.x, dec_o.y, dec_o.z} = {lo, c, hi};
            m0 = s ? -CoefHalfSqrt3 : -CoefHalf;
            m1 = s ? CoefHalf : -CoefHalfSqrt3;
          end else begin
            dec_o.cnt  = TermsOne;
            dec_o.pair = 1'b1;
            dec_o.x    = hi;
            dec_o.z    = lo;
            m0 = s ? CoefHalfSqrt6 : -CoefHalfSqrt2;
          end
        end
      end else if (s && a != b && b != c && c != a) begin
        dec_o.cnt   = TermsOne;
        dec_o.quart = 1'b1;
        m0          = CoefOne;
        if (a < b) begin
          if (b < c) begin
            {dec_o.x, dec_o.y, dec_o.z} = {a, b, c};
          end else if (c < a) begin
            {dec_o.x, dec_o.y, dec_o.z} = {c, a, b};
          end else begin
            {dec_o.x, dec_o.y, dec_o.z} = {a, c, b};
            neg = 1'b1;
          end
        end else begin
          if (a < c) begin
            {dec_o.x, dec_o.y, dec_o.z} = {b, a, c};
            neg = 1'b1;
          end else if (c < b) begin
            {dec_o.x, dec_o.y, dec_o.z} = {c, b, a};
            neg = 1'b1;
          end else begin
            {dec_o.x, dec_o.y, dec_o.z} = {b, c, a};
          end
        end
      end
    end
    dec_o.coef0 = neg ? -m0 : m0;
    dec_o.coef1 = neg ? -m1 : m1;
  end

endmodule

// ===== design/spin_adapted_triple_index_map_unit.sv =====
// top level of the spin-adapted triple index map: four-stage lookup pipeline
//
// usage
// - input channel (in_valid_i / in_ready_o) carries one item: spin block,
//   pair spin and three orbital indices
// - output channel (out_valid_o / out_ready_i) returns one result per item:
//   term count, up to two linear basis indices and their q2.16 coefficients
// - cfg_we_i writes the spatial orbital count from cfg_wdata_i;
//   write it only while no item is in flight
// - out_valid_o rises once the item has passed the four register stages
//   (decode, binomial table lookup, index sum, output select); one item
//   per cycle is taken and delivered while the receiver does not stall
// - a stalled receiver holds the output register; each stage only moves
//   when the stage after it is empty or moving, so bubbles are squeezed
//   out and in_ready_o drops only when all four stages hold an item
// - reset empties the pipeline and loads sixteen spatial orbitals
module spin_adapted_triple_index_map_unit import satim_pkg::*; #(
  parameter int MAX_ORBITALS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [NumWidth-1:0]         cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        spin_block_i,
  input  logic                        pair_spin_i,
  input  logic [OrbWidth-1:0]         orbital_first_i,
  input  logic [OrbWidth-1:0]         orbital_second_i,
  input  logic [OrbWidth-1:0]         orbital_third_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [CountWidth-1:0]       term_count_o,
  output logic [IndexWidth-1:0]       index_zero_o,
  output logic signed [CoefWidth-1:0] coef_zero_o,
  output logic [IndexWidth-1:0]       index_one_o,
  output logic signed [CoefWidth-1:0] coef_one_o
);

`include "spin_adapted_triple_index_map_unit_macros.svh"

  // table lookup results, stage two
  typedef struct packed {
    logic [CountWidth-1:0]       cnt;
    logic                        pair;
    logic signed [CoefWidth-1:0] coef0;
    logic signed [CoefWidth-1:0] coef1;
    logic [CalcWidth-1:0]        base;
    logic [CalcWidth-1:0]        c3n;
    logic [CalcWidth-1:0]        c3x;
    logic [CalcWidth-1:0]        c2x;
    logic [CalcWidth-1:0]        c2y;
    logic [CalcWidth-1:0]        cz;
    logic [CalcWidth-1:0]        prod;
    logic [CalcWidth-1:0]        off;
  } look_t;

  // summed indices, stage three
  typedef struct packed {
    logic [CountWidth-1:0]       cnt;
    logic                        pair;
    logic signed [CoefWidth-1:0] coef0;
    logic signed [CoefWidth-1:0] coef1;
    logic [CalcWidth-1:0]        tri_idx;
    logic [CalcWidth-1:0]        pair_idx;
    logic [CalcWidth-1:0]        c3n;
  } sum_t;

  logic [NumWidth-1:0] spatial_orbitals_q;

  dec_t  dec;
  dec_t  s1_q;
  look_t s2_d, s2_q;
  sum_t  s3_d, s3_q;
  logic  v1_q, v2_q, v3_q, v4_q;
  logic  rdy1, rdy2, rdy3, rdy4;

  logic [NumWidth-1:0]  n_minus_x;
  logic [CalcWidth-1:0] c2n, idx1_sum;

  logic [CountWidth-1:0]       cnt_q;
  logic [IndexWidth-1:0]       idx0_q, idx1_q;
  logic signed [CoefWidth-1:0] cf0_q, cf1_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spatial_orbitals_q <= SpatialOrbitalsReset;
    end else if (cfg_we_i) begin
      spatial_orbitals_q <= cfg_wdata_i;
    end
  end

  // ready chain: a stage moves when the next one is empty or moving
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // stage one: decode
  satim_decode #(
    .MAX_ORBITALS(MAX_ORBITALS)
  ) u_decode (
    .spatial_orbitals_i(spatial_orbitals_q),
    .spin_block_i      (spin_block_i),
    .pair_spin_i       (pair_spin_i),
    .orbital_first_i   (orbital_first_i),
    .orbital_second_i  (orbital_second_i),
    .orbital_third_i   (orbital_third_i),
    .dec_o             (dec)
  );

  // stage two: binomial lookups and the pair product
  assign n_minus_x = s1_q.n - NumWidth'(s1_q.x);
  assign c2n       = Choose2Table[s1_q.n];

  always_comb begin
    s2_d       = '0;
    s2_d.cnt   = s1_q.cnt;
    s2_d.pair  = s1_q.pair;
    s2_d.coef0 = s1_q.coef0;
    s2_d.coef1 = s1_q.coef1;
    s2_d.c3n   = Choose3Table[s1_q.n];
    s2_d.c3x   = Choose3Table[n_minus_x];
    s2_d.c2x   = Choose2Table[n_minus_x - NumWidth'(1)];
    s2_d.c2y   = Choose2Table[s1_q.n - NumWidth'(s1_q.y)];
    s2_d.cz    = CalcWidth'(s1_q.z) - CalcWidth'(s1_q.y) - CalcWidth'(1);
    // pair states come first, then the spin zero and spin one triples
    s2_d.base  = s1_q.quart ? '0
                            : ({c2n[CalcWidth-2:0], 1'b0} +
                               (s1_q.spin1 ? Choose3Table[s1_q.n] : '0));
    s2_d.prod  = CalcWidth'(s1_q.x) * CalcWidth'(s1_q.n - NumWidth'(1));
    s2_d.off   = (s1_q.z < s1_q.x) ? CalcWidth'(s1_q.z)
                                   : CalcWidth'(s1_q.z) - CalcWidth'(1);
  end

  // stage three: lexicographic rank and pair index sums
  always_comb begin
    s3_d.cnt      = s2_q.cnt;
    s3_d.pair     = s2_q.pair;
    s3_d.coef0    = s2_q.coef0;
    s3_d.coef1    = s2_q.coef1;
    s3_d.c3n      = s2_q.c3n;
    s3_d.tri_idx  = s2_q.base + s2_q.c3n - s2_q.c3x + s2_q.c2x - s2_q.c2y + s2_q.cz;
    s3_d.pair_idx = s2_q.prod + s2_q.off;
  end

  // second term is the same triple with pair spin one
  assign idx1_sum = s3_q.tri_idx + s3_q.c3n;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_q <= dec;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
    if (rdy4 && v3_q) begin
      cnt_q  <= s3_q.cnt;
      idx0_q <= (s3_q.cnt == TermsNone) ? '0
              : s3_q.pair ? s3_q.pair_idx[IndexWidth-1:0]
                          : s3_q.tri_idx[IndexWidth-1:0];
      cf0_q  <= (s3_q.cnt == TermsNone) ? '0 : s3_q.coef0;
      idx1_q <= (s3_q.cnt == TermsTwo) ? idx1_sum[IndexWidth-1:0] : '0;
      cf1_q  <= (s3_q.cnt == TermsTwo) ? s3_q.coef1 : '0;
    end
  end

  assign out_valid_o  = v4_q;
  assign term_count_o = cnt_q;
  assign index_zero_o = idx0_q;
  assign coef_zero_o  = cf0_q;
  assign index_one_o  = idx1_q;
  assign coef_one_o   = cf1_q;

  // checks
  `SATIM_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o && in_ready_o, "pipeline not empty in reset")
  `SATIM_ASSERT(a_full_on_stall, !in_ready_o |-> v1_q && v2_q && v3_q && out_valid_o && !out_ready_i, "input blocked with a free stage")
  `SATIM_ASSERT(a_count_range, out_valid_o |-> term_count_o != 2'd3, "term count out of range")
  `SATIM_ASSERT(a_unused_zero, out_valid_o && term_count_o != TermsTwo |-> index_one_o == '0 && coef_one_o == '0, "second term not cleared")

endmodule

// ===== tb/spin_adapted_triple_index_map_unit_tb.sv =====
// testbench of the triple index map unit: directed table, random items, predictor
module spin_adapted_triple_index_map_unit_tb;
  import satim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxOrbitals = 16;
  localparam int ItemsPerPhase = 250;
  localparam int NumPhases = 8;
  localparam int NumRows = 26;
  // pipeline depth plus margin
  localparam int SettleCycles = 8;

  // q2.16 coefficient magnitudes
  localparam int QOne       = 65536;
  localparam int QHalf      = 32768;
  localparam int QHalfSqrt3 = 56756;
  localparam int QHalfSqrt2 = 46341;
  localparam int QHalfSqrt6 = 80265;

  // idling styles, one per random phase
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // one result item as the unit presents it
  typedef struct packed {
    logic [CountWidth-1:0]       cnt;
    logic [IndexWidth-1:0]       idx0;
    logic signed [CoefWidth-1:0] cf0;
    logic [IndexWidth-1:0]       idx1;
    logic signed [CoefWidth-1:0] cf1;
  } term_set_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    int        n;
    bit        blk;
    bit        s;
    int        a;
    int        b;
    int        c;
    bit        typed;
    term_set_t want;
  } stim_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [NumWidth-1:0]         cfg_wdata_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic                        spin_block_i = 1'b0;
  logic                        pair_spin_i = 1'b0;
  logic [OrbWidth-1:0]         orbital_first_i = '0;
  logic [OrbWidth-1:0]         orbital_second_i = '0;
  logic [OrbWidth-1:0]         orbital_third_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b1;
  logic [CountWidth-1:0]       term_count_o;
  logic [IndexWidth-1:0]       index_zero_o;
  logic signed [CoefWidth-1:0] coef_zero_o;
  logic [IndexWidth-1:0]       index_one_o;
  logic signed [CoefWidth-1:0] coef_one_o;

  // expected results in order of acceptance
  term_set_t           pending_terms [$];
  term_set_t           want_terms;
  term_set_t           got_terms;
  // printable forms of the compared items
  string               want_txt;
  string               got_txt;
  // testbench copy of the spatial orbital register
  logic [NumWidth-1:0] orbitals = SpatialOrbitalsReset;
  int                  mismatches = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  stim_row_t           dir_rows [NumRows];

  spin_adapted_triple_index_map_unit #(
    .MAX_ORBITALS(MaxOrbitals)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .spin_block_i    (spin_block_i),
    .pair_spin_i     (pair_spin_i),
    .orbital_first_i (orbital_first_i),
    .orbital_second_i(orbital_second_i),
    .orbital_third_i (orbital_third_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .term_count_o    (term_count_o),
    .index_zero_o    (index_zero_o),
    .coef_zero_o     (coef_zero_o),
    .index_one_o     (index_one_o),
    .coef_one_o      (coef_one_o)
  );

  // 12 ns clock, 6 ns high and 6 ns low
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // binomials used by the basis enumeration
  function automatic int binom2(input int x);
    return x * (x - 1) / 2;
  endfunction

  function automatic int binom3(input int x);
    return x * (x - 1) * (x - 2) / 6;
  endfunction

  // lexicographic rank of a<b<c out of n orbitals
  function automatic int lex_rank(input int n, input int a, input int b, input int c);
    return binom3(n) - binom3(n - a) + binom2(n - a - 1) - binom2(n - b) + (c - b - 1);
  endfunction

  // doublet index of the pair state (a,a,c)
  function automatic int pair_slot(input int n, input int a, input int c);
    return a * (n - 1) + ((c < a) ? c : c - 1);
  endfunction

  // doublet index of the ordered triple a<b<c with pair spin s
  function automatic int triple_slot(input int n, input int s, input int a, input int b,
                                     input int c);
    return n * (n - 1) + s * binom3(n) + lex_rank(n, a, b, c);
  endfunction

  // expected expansion of one item for a given register value
  function automatic term_set_t predict_terms(input logic [NumWidth-1:0] n_reg, input bit blk,
                                              input bit s_bit, input int a, input int b,
                                              input int c);
    int        n;
    int        s;
    int        cnt;
    int        i0;
    int        i1;
    int        c0;
    int        c1;
    int        lo;
    int        hi;
    int        p;
    term_set_t r;
    n = (int'(n_reg) > MaxOrbitals) ? MaxOrbitals : int'(n_reg);
    s = int'(s_bit);
    cnt = 0;
    i0 = 0;
    i1 = 0;
    c0 = 0;
    c1 = 0;
    if (a < n && b < n && c < n && !(a == b && b == c)) begin
      if (!blk) begin
        // spin 1/2 block
        if (a == b) begin
          if (s == 0) begin
            cnt = 1;
            i0 = pair_slot(n, a, c);
            c0 = QOne;
          end
        end else if (a < b && b < c) begin
          cnt = 1;
          i0 = triple_slot(n, s, a, b, c);
          c0 = QOne;
        end else if (a > b && c > a) begin
          // swapping the first two flips the sign for pair spin 1
          cnt = 1;
          i0 = triple_slot(n, s, b, a, c);
          c0 = s ? -QOne : QOne;
        end else begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          p = (a < b || s == 0) ? 1 : -1;
          if (c < lo) begin
            cnt = 2;
            i0 = triple_slot(n, 0, c, lo, hi);
            i1 = triple_slot(n, 1, c, lo, hi);
            c0 = p * (s ? -QHalfSqrt3 : -QHalf);
            c1 = p * (s ? -QHalf : QHalfSqrt3);
          end else if (c == lo) begin
            cnt = 1;
            i0 = pair_slot(n, c, hi);
            c0 = p * (s ? -QHalfSqrt6 : -QHalfSqrt2);
          end else if (c < hi) begin
            cnt = 2;
            i0 = triple_slot(n, 0, lo, c, hi);
            i1 = triple_slot(n, 1, lo, c, hi);
            c0 = p * (s ? -QHalfSqrt3 : -QHalf);
            c1 = p * (s ? QHalf : -QHalfSqrt3);
          end else begin
            cnt = 1;
            i0 = pair_slot(n, hi, lo);
            c0 = p * (s ? QHalfSqrt6 : -QHalfSqrt2);
          end
        end
      end else if (s != 0 && a != b && b != c && c != a) begin
        // spin 3/2 block: sign of the sorting permutation
        cnt = 1;
        if (a < b) begin
          if (b < c) begin
            i0 = lex_rank(n, a, b, c);
            c0 = QOne;
          end else if (c < a) begin
            i0 = lex_rank(n, c, a, b);
            c0 = QOne;
          end else begin
            i0 = lex_rank(n, a, c, b);
            c0 = -QOne;
          end
        end else begin
          if (a < c) begin
            i0 = lex_rank(n, b, a, c);
            c0 = -QOne;
          end else if (c < b) begin
            i0 = lex_rank(n, c, b, a);
            c0 = -QOne;
          end else begin
            i0 = lex_rank(n, b, c, a);
            c0 = QOne;
          end
        end
      end
    end
    r.cnt = CountWidth'(cnt);
    r.idx0 = IndexWidth'(i0);
    r.cf0 = CoefWidth'(c0);
    r.idx1 = IndexWidth'(i1);
    r.cf1 = CoefWidth'(c1);
    return r;
  endfunction

  // offer one item, with random gaps before it, and record its expected result on acceptance;
  // entered and left at a falling edge
  task automatic send_item(input bit blk, input bit s, input logic [OrbWidth-1:0] a,
                           input logic [OrbWidth-1:0] b, input logic [OrbWidth-1:0] c,
                           input bit typed, input term_set_t want);
    bit accepted;
    accepted = 1'b0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    spin_block_i <= blk;
    pair_spin_i <= s;
    orbital_first_i <= a;
    orbital_second_i <= b;
    orbital_third_i <= c;
    while (!accepted) begin
      @(posedge clk_i);
      if (in_ready_o) begin
        accepted = 1'b1;
        pending_terms.push_back(typed ? want : predict_terms(orbitals, blk, s, a, b, c));
      end
    end
    @(negedge clk_i);
  endtask

  // hold the sender off until every expected result is back, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_terms.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // write the orbital count while the unit is idle
  task automatic set_orbitals(input logic [NumWidth-1:0] v);
    drain_results();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    orbitals = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // receiver side: random stalls per the current phase
  always @(negedge clk_i) begin
    out_ready_i <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // scoreboard: each delivered item against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_terms = {term_count_o, index_zero_o, coef_zero_o, index_one_o, coef_one_o};
      got_txt = $sformatf("cnt=%0d idx0=%0d cf0=%0d idx1=%0d cf1=%0d", got_terms.cnt,
                          got_terms.idx0, got_terms.cf0, got_terms.idx1, got_terms.cf1);
      if (pending_terms.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %s", $time, got_txt);
      end else begin
        want_terms = pending_terms.pop_front();
        if (got_terms !== want_terms) begin
          mismatches++;
          want_txt = $sformatf("cnt=%0d idx0=%0d cf0=%0d idx1=%0d cf1=%0d", want_terms.cnt,
                               want_terms.idx0, want_terms.cf0, want_terms.idx1,
                               want_terms.cf1);
          $display("%0t: expected %s, actual %s", $time, want_txt, got_txt);
        end
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    int           phase_n [NumPhases];
    idle_mode_e   phase_mode;
    int           roll;
    int           eff_n;
    int           k;
    bit           blk;
    bit           s;
    logic [OrbWidth-1:0] a;
    logic [OrbWidth-1:0] b;
    logic [OrbWidth-1:0] c;

    // register settings per random phase, extremes and a clamped value among them
    phase_n = '{16, 3, 7, 31, 12, 5, 16, 9};

    // directed table: n, spin block, pair spin, a, b, c, typed, typed result
    dir_rows = '{
      // all orbitals equal, at both extremes
      '{16, 1'b0, 1'b0, 0, 0, 0, 1'b1, '{2'd0, 11'd0, 18'sd0, 11'd0, 18'sd0}},
      '{16, 1'b0, 1'b0, 15, 15, 15, 1'b1, '{2'd0, 11'd0, 18'sd0, 11'd0, 18'sd0}},
      // doubly occupied pair with pair spin 1
      '{16, 1'b0, 1'b1, 3, 3, 5, 1'b1, '{2'd0, 11'd0, 18'sd0, 11'd0, 18'sd0}},
      // a pair state, the first spin zero triple and the last entry of the doublet basis
      '{16, 1'b0, 1'b0, 0, 0, 15, 1'b1, '{2'd1, 11'd14, 18'sd65536, 11'd0, 18'sd0}},
      '{16, 1'b0, 1'b0, 0, 1, 2, 1'b1, '{2'd1, 11'd240, 18'sd65536, 11'd0, 18'sd0}},
      '{16, 1'b0, 1'b1, 13, 14, 15, 1'b1, '{2'd1, 11'd1359, 18'sd65536, 11'd0, 18'sd0}},
      // quartet with pair spin 0, or with a repeated orbital, then the first quartet entry
      '{16, 1'b1, 1'b0, 0, 1, 2, 1'b1, '{2'd0, 11'd0, 18'sd0, 11'd0, 18'sd0}},
      '{16, 1'b1, 1'b1, 1, 1, 2, 1'b1, '{2'd0, 11'd0, 18'sd0, 11'd0, 18'sd0}},
      '{16, 1'b1, 1'b1, 0, 1, 2, 1'b1, '{2'd1, 11'd0, 18'sd65536, 11'd0, 18'sd0}},
      // quartet permutations
      '{16, 1'b1, 1'b1, 0, 2, 1, 1'b0, '0},
      '{16, 1'b1, 1'b1, 2, 0, 1, 1'b0, '0},
      '{16, 1'b1, 1'b1, 1, 0, 2, 1'b0, '0},
      '{16, 1'b1, 1'b1, 2, 1, 0, 1'b0, '0},
      '{16, 1'b1, 1'b1, 15, 14, 13, 1'b0, '0},
      // doublet recoupling: swapped pair, third below, equal, between, at the top
      '{16, 1'b0, 1'b1, 2, 1, 5, 1'b0, '0},
      '{16, 1'b0, 1'b0, 5, 7, 1, 1'b0, '0},
      '{16, 1'b0, 1'b1, 9, 4, 1, 1'b0, '0},
      '{16, 1'b0, 1'b0, 3, 6, 3, 1'b0, '0},
      '{16, 1'b0, 1'b1, 6, 3, 3, 1'b0, '0},
      '{16, 1'b0, 1'b0, 2, 9, 5, 1'b0, '0},
      '{16, 1'b0, 1'b1, 9, 2, 5, 1'b0, '0},
      '{16, 1'b0, 1'b1, 2, 6, 6, 1'b0, '0},
      '{16, 1'b0, 1'b0, 6, 2, 6, 1'b0, '0},
      // smallest orbital count: orbital out of range, then a reversed triple
      '{3, 1'b0, 1'b0, 0, 0, 3, 1'b1, '{2'd0, 11'd0, 18'sd0, 11'd0, 18'sd0}},
      '{3, 1'b1, 1'b1, 2, 1, 0, 1'b1, '{2'd1, 11'd0, -18'sd65536, 11'd0, 18'sd0}},
      // register above the maximum is clamped
      '{31, 1'b1, 1'b1, 13, 14, 15, 1'b1, '{2'd1, 11'd559, 18'sd65536, 11'd0, 18'sd0}}
    };

    // hold reset, then release it
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling
    foreach (dir_rows[i]) begin
      if (NumWidth'(dir_rows[i].n) != orbitals) begin
        set_orbitals(NumWidth'(dir_rows[i].n));
      end
      send_item(dir_rows[i].blk, dir_rows[i].s, OrbWidth'(dir_rows[i].a),
                OrbWidth'(dir_rows[i].b), OrbWidth'(dir_rows[i].c), dir_rows[i].typed,
                dir_rows[i].want);
    end

    // random phases, each with its own register value and idling style
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_orbitals(NumWidth'(phase_n[ph]));
      phase_mode = idle_mode_e'(ph % 4);
      case (phase_mode)
        IdleNone: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        IdleSender: begin
          idle_pct = 71;
          stall_pct = 0;
        end
        IdleReceiver: begin
          idle_pct = 0;
          stall_pct = 71;
        end
        default: begin
          idle_pct = 34;
          stall_pct = 34;
        end
      endcase
      eff_n = (int'(orbitals) > MaxOrbitals) ? MaxOrbitals : int'(orbitals);
      for (k = 0; k < ItemsPerPhase; k++) begin
        // mid-phase the sender waits for the pipe to empty
        if (k == ItemsPerPhase / 2) begin
          drain_results();
        end
        blk = 1'($urandom_range(1));
        s = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 12) begin
          // noise: any orbital value, often out of range
          a = OrbWidth'($urandom_range(15));
          b = OrbWidth'($urandom_range(15));
          c = OrbWidth'($urandom_range(15));
        end else begin
          a = OrbWidth'($urandom_range(eff_n - 1));
          b = OrbWidth'($urandom_range(eff_n - 1));
          c = OrbWidth'($urandom_range(eff_n - 1));
          // force a repeated orbital now and then
          if (roll < 40) begin
            case ($urandom_range(2))
              0: b = a;
              1: c = a;
              default: c = b;
            endcase
          end
        end
        send_item(blk, s, a, b, c, 1'b0, '0);
      end
    end

    // wind down: no more stalls, wait for the last results
    in_valid_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (pending_terms.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_terms.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
